@@ design/strip_fan_to_triangle_list_core_assert.svh @@
// Assertion macros shared by the strip and fan expansion modules.
`ifndef STRIP_FAN_TO_TRIANGLE_LIST_CORE_ASSERT_SVH
`define STRIP_FAN_TO_TRIANGLE_LIST_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define STFL_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define STFL_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STFL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/stfl_pkg.sv @@
// Shared types and constants for the strip and fan expansion core.
package stfl_pkg;

    localparam int MaxVertices    = 2048;
    localparam int MaxPrimRecords = 4095;
    localparam int QueueDepth     = 2;
    localparam logic [11:0] VertexCountReset = 12'd2048;

    localparam int InDataW  = 88;
    localparam int OutDataW = 80;
    localparam int OutUserW = 3;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_COUNT = 2'd1,
        ERR_INDEX = 2'd2,
        ERR_PLACE = 2'd3
    } err_t;

    typedef struct packed {
        logic [31:0] s;
        logic [31:0] t;
        logic [10:0] idx;
    } vert_t;

    // One queued job: either a single status word or a whole triangle.
    typedef struct packed {
        logic  is_tri;
        logic  done;
        err_t  err;
        vert_t v0;
        vert_t v1;
        vert_t v2;
    } job_t;

endpackage

@@ design/stfl_front.sv @@
// Front end: accepts command words, tracks primitive state and builds jobs.
module stfl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic signed [12:0]   prim_count,
    input  logic [31:0]          tex_s,
    input  logic [31:0]          tex_t,
    input  logic [10:0]          vert_index,
    input  logic [11:0]          vertex_count,
    input  logic                 q_full,
    output logic                 q_push,
    output stfl_pkg::job_t       q_job
);

    logic                  in_prim_reg, in_prim_next;
    logic                  is_fan_reg, is_fan_next;
    logic [11:0]           left_reg, left_next;
    logic [1:0]            pos_reg, pos_next;      // saturates at two
    logic                  odd_reg, odd_next;      // parity of record position
    stfl_pkg::vert_t       held_reg [2];
    stfl_pkg::vert_t       cur_v, va, vb;
    logic                  take;
    logic                  neg;
    logic [12:0]           mag;
    logic                  swap;
    logic                  ok_a, ok_b, ok_c;

    function automatic logic index_ok(input logic [10:0] idx, input logic [11:0] lim);
        index_ok = ({1'b0, idx} < lim) && (32'(idx) < stfl_pkg::MaxVertices);
    endfunction

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign cur_v = '{s: tex_s, t: tex_t, idx: vert_index};
    assign neg   = prim_count[12];
    assign mag   = neg ? 13'(13'd0 - prim_count) : prim_count;
    assign swap  = !is_fan_reg && odd_reg;
    assign va    = swap ? held_reg[1] : held_reg[0];
    assign vb    = swap ? held_reg[0] : held_reg[1];
    assign ok_a  = index_ok(va.idx, vertex_count);
    assign ok_b  = index_ok(vb.idx, vertex_count);
    assign ok_c  = index_ok(vert_index, vertex_count);

    // Classify the word and decide the job and next state
    always_comb begin
        in_prim_next = in_prim_reg;
        is_fan_next  = is_fan_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        odd_next     = odd_reg;
        q_push       = 1'b0;
        q_job        = '0;
        q_job.err    = stfl_pkg::ERR_NONE;
        if (take) begin
            if (!action) begin
                q_push = 1'b1;
                if (in_prim_reg) begin
                    q_job.err = stfl_pkg::ERR_PLACE;
                end else if (mag == 13'd0) begin
                    q_job.done = 1'b1;
                end else if (mag < 13'd3 || mag > 13'(stfl_pkg::MaxPrimRecords)) begin
                    q_job.err = stfl_pkg::ERR_COUNT;
                end else begin
                    q_push       = 1'b0;
                    in_prim_next = 1'b1;
                    is_fan_next  = neg;
                    left_next    = mag[11:0];
                    pos_next     = 2'd0;
                    odd_next     = 1'b0;
                end
            end else if (!in_prim_reg) begin
                q_push    = 1'b1;
                q_job.err = stfl_pkg::ERR_PLACE;
            end else begin
                if (pos_reg != 2'd2) begin
                    if (!ok_c) begin
                        q_push    = 1'b1;
                        q_job.err = stfl_pkg::ERR_INDEX;
                    end
                    pos_next = 2'(pos_reg + 2'd1);
                end else begin
                    q_push = 1'b1;
                    if (ok_a && ok_b && ok_c) begin
                        q_job.is_tri = 1'b1;
                        q_job.v0     = va;
                        q_job.v1     = vb;
                        q_job.v2     = cur_v;
                    end else begin
                        q_job.err = stfl_pkg::ERR_INDEX;
                    end
                end
                odd_next  = !odd_reg;
                left_next = 12'(left_reg - 12'd1);
                if (left_reg == 12'd1) begin
                    in_prim_next = 1'b0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_prim_reg <= 1'b0;
            is_fan_reg  <= 1'b0;
            left_reg    <= '0;
            pos_reg     <= '0;
            odd_reg     <= 1'b0;
        end else begin
            in_prim_reg <= in_prim_next;
            is_fan_reg  <= is_fan_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            odd_reg     <= odd_next;
        end
    end

    // Hold the last two records; a strip slides, a fan keeps its pivot
    always_ff @(posedge aclk) begin
        if (take && action && in_prim_reg) begin
            if (pos_reg != 2'd2) begin
                held_reg[pos_reg[0]] <= cur_v;
            end else begin
                if (!is_fan_reg) begin
                    held_reg[0] <= held_reg[1];
                end
                held_reg[1] <= cur_v;
            end
        end
    end

endmodule

@@ design/stfl_queue.sv @@
// Short job queue between the front end and the output sequencer.
`include "strip_fan_to_triangle_list_core_assert.svh"

module stfl_queue #(
    parameter int DEPTH = stfl_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  stfl_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output stfl_pkg::job_t  head_job
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    stfl_pkg::job_t    mem [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    // Write the entry at the tail
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CntW'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CntW'(count_reg - 1'b1);
            end
        end
    end

    `STFL_ASSERT_ALWAYS(a_q_bound, aclk, aresetn, count_reg <= CntW'(DEPTH), "queue overfilled")
    `STFL_ASSERT_IMPLIES(a_q_nopush_full, aclk, aresetn, full, !push, "push into full queue")
    `STFL_ASSERT_NEXT(a_q_grow, aclk, aresetn, push && !pop, count_reg != '0, "push lost")

endmodule

@@ design/stfl_back.sv @@
// Back end: walks each job out as result words through an output register.
`include "strip_fan_to_triangle_list_core_assert.svh"

module stfl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  stfl_pkg::job_t       head_job,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stfl_pkg::vert_t      out_vert,
    output logic                 tri_last,
    output logic                 list_done,
    output stfl_pkg::err_t       error_code
);

    logic             phase_reg, phase_next_unused;
    logic [1:0]       step_reg;
    logic             valid_reg;
    stfl_pkg::vert_t  vert_reg, vert_sel;
    logic             last_reg, done_reg;
    stfl_pkg::err_t   err_reg;
    logic             load;
    logic             final_step;

    assign phase_reg         = (step_reg != 2'd0);
    assign phase_next_unused = 1'b0;
    assign load       = head_valid && (!valid_reg || out_ready);
    assign final_step = !head_job.is_tri || (step_reg == 2'd2);
    assign pop        = load && final_step;

    // Pick the vertex for the current step
    always_comb begin
        unique case (step_reg)
            2'd0:    vert_sel = head_job.v0;
            2'd1:    vert_sel = head_job.v1;
            default: vert_sel = head_job.v2;
        endcase
        if (!head_job.is_tri || phase_next_unused) begin
            vert_sel = '0;
        end
    end

    // Step through the job and hold the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= final_step ? 2'd0 : 2'(step_reg + 2'd1);
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output word
    always_ff @(posedge aclk) begin
        if (load) begin
            vert_reg <= vert_sel;
            last_reg <= head_job.is_tri && (step_reg == 2'd2);
            done_reg <= head_job.done;
            err_reg  <= head_job.err;
        end
    end

    assign out_valid  = valid_reg;
    assign out_vert   = vert_reg;
    assign tri_last   = last_reg;
    assign list_done  = done_reg;
    assign error_code = err_reg;

    `STFL_ASSERT_IMPLIES(a_b_mid_tri, aclk, aresetn, phase_reg,
        head_valid && head_job.is_tri, "mid-triangle without a triangle job")
    `STFL_ASSERT_IMPLIES(a_b_last_clean, aclk, aresetn, valid_reg && last_reg,
        err_reg == stfl_pkg::ERR_NONE && !done_reg, "triangle end carries status")
    `STFL_ASSERT_NEXT(a_b_stall_hold, aclk, aresetn, valid_reg && !out_ready,
        valid_reg && step_reg == $past(step_reg), "stalled word moved on")

endmodule

@@ design/strip_fan_to_triangle_list_core.sv @@
// Top level of the triangle strip and fan to triangle list core.
//
// Input channel s_*: one command word per handshake. s_tuser is the action
// (0 header or terminator, 1 vertex record). A header opens a strip
// (positive count) or a fan (negative count); zero ends the list.
// Output channel m_*: one vertex or status word per handshake. From the
// third record of a primitive on, each record yields three words with
// m_tlast on the third; error, terminator and misplaced-item words come
// singly with vertex fields zero.
// Configuration: cfg_valid/cfg_data write vertex_count; always ready.
// Path: each job is registered in the queue, then each word in the output register.
// Throughput: the front end takes one item per cycle while its two-entry
// job queue has room; the output register emits one word per cycle while
// m_tready is high, so a record that makes a triangle yields three words.
// Headers that open a primitive produce no word.
// Reset (aresetn low, synchronous) empties the queue, closes any open
// primitive and sets vertex_count to 2048. When m_tready is low the output
// word holds, the queue fills and s_tready drops.
module strip_fan_to_triangle_list_core #(
    parameter int QUEUE_DEPTH = stfl_pkg::QueueDepth
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [12:0] prim_count, [44:13] tex_s, [76:45] tex_t, [87:77] vert_index
    input  logic [stfl_pkg::InDataW-1:0]  s_tdata,
    // [0] action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] out_s, [63:32] out_t, [74:64] out_index, [79:75] zero
    output logic [stfl_pkg::OutDataW-1:0] m_tdata,
    output logic                          m_tlast,
    // [0] list_done, [2:1] error_code
    output logic [stfl_pkg::OutUserW-1:0] m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [11:0]                   cfg_data
);

    logic [11:0]      vertex_count_reg;
    logic             q_full, q_push, q_pop, q_head_valid;
    stfl_pkg::job_t   q_job, q_head;
    stfl_pkg::vert_t  out_vert;
    logic             list_done;
    stfl_pkg::err_t   error_code;

    // Hold the vertex count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= stfl_pkg::VertexCountReset;
        end else if (cfg_valid && cfg_ready) begin
            vertex_count_reg <= cfg_data;
        end
    end

    stfl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .action       (s_tuser),
        .prim_count   (s_tdata[12:0]),
        .tex_s        (s_tdata[44:13]),
        .tex_t        (s_tdata[76:45]),
        .vert_index   (s_tdata[87:77]),
        .vertex_count (vertex_count_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    stfl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head)
    );

    stfl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_vert   (out_vert),
        .tri_last   (m_tlast),
        .list_done  (list_done),
        .error_code (error_code)
    );

    // Pack the output word
    assign m_tdata = {5'd0, out_vert.idx, out_vert.t, out_vert.s};
    assign m_tuser = {error_code, list_done};

endmodule

@@ verif/strip_fan_to_triangle_list_core_tb.sv @@
// Self-checking testbench for the strip and fan to triangle list core.
module strip_fan_to_triangle_list_core_tb;

    localparam int StallLimit = 2000;
    localparam int DrainCycles = 8;
    localparam int RandomItemsPerPhase = 34;
    localparam int LongPrimRecords = 12;

    // One expected output word, field by field
    typedef struct packed {
        logic [31:0]     s;
        logic [31:0]     t;
        logic [10:0]     idx;
        logic            last;
        logic            done;
        stfl_pkg::err_t  err;
    } tri_word_t;

    // Primitive assembly predictor and store of words still due
    class tri_list_scoreboard;
        logic [11:0]      vertex_limit;
        bit               open_prim;
        bit               fan_mode;
        logic [11:0]      records_due;
        logic [11:0]      position;
        stfl_pkg::vert_t  held [2];
        tri_word_t        words_due [$];
        int               errors;

        function new();
            vertex_limit = stfl_pkg::VertexCountReset;
            open_prim    = 1'b0;
            fan_mode     = 1'b0;
            records_due  = '0;
            position     = '0;
            errors       = 0;
        endfunction

        function void set_vertex_count(logic [11:0] v);
            vertex_limit = v;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function bit index_in_range(logic [10:0] i);
            int lim;
            lim = (vertex_limit > stfl_pkg::MaxVertices) ? stfl_pkg::MaxVertices : vertex_limit;
            return i < lim;
        endfunction

        function void push_status(stfl_pkg::err_t e, logic done);
            tri_word_t w;
            w = '{s: '0, t: '0, idx: '0, last: 1'b0, done: done, err: e};
            words_due.push_back(w);
        endfunction

        function void push_vertex(stfl_pkg::vert_t v, logic last);
            tri_word_t w;
            w = '{s: v.s, t: v.t, idx: v.idx, last: last, done: 1'b0,
                  err: stfl_pkg::ERR_NONE};
            words_due.push_back(w);
        endfunction

        // Predict the words caused by one accepted input word
        function void note_item(logic act, logic [12:0] cnt, logic [31:0] s,
                                logic [31:0] t, logic [10:0] idx);
            logic [12:0]      mag;
            stfl_pkg::vert_t  cur;
            int               a;
            int               b;
            cur = '{s: s, t: t, idx: idx};
            if (!act) begin
                mag = cnt[12] ? (13'd0 - cnt) : cnt;
                if (open_prim) begin
                    push_status(stfl_pkg::ERR_PLACE, 1'b0);
                end else if (mag == 0) begin
                    push_status(stfl_pkg::ERR_NONE, 1'b1);
                end else if (mag < 3 || mag > stfl_pkg::MaxPrimRecords) begin
                    push_status(stfl_pkg::ERR_COUNT, 1'b0);
                end else begin
                    open_prim   = 1'b1;
                    fan_mode    = cnt[12];
                    records_due = mag[11:0];
                    position    = '0;
                end
                return;
            end
            if (!open_prim) begin
                push_status(stfl_pkg::ERR_PLACE, 1'b0);
                return;
            end
            if (position < 2) begin
                held[position[0]] = cur;
                if (!index_in_range(idx))
                    push_status(stfl_pkg::ERR_INDEX, 1'b0);
            end else begin
                // odd strip triangles swap their first two vertices
                a = (!fan_mode && position[0]) ? 1 : 0;
                b = 1 - a;
                if (!index_in_range(held[a].idx) || !index_in_range(held[b].idx) ||
                    !index_in_range(idx)) begin
                    push_status(stfl_pkg::ERR_INDEX, 1'b0);
                end else begin
                    push_vertex(held[a], 1'b0);
                    push_vertex(held[b], 1'b0);
                    push_vertex(cur, 1'b1);
                end
                if (!fan_mode)
                    held[0] = held[1];
                held[1] = cur;
            end
            position = position + 12'd1;
            if (records_due > 0)
                records_due = records_due - 12'd1;
            if (records_due == 0)
                open_prim = 1'b0;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Check one accepted output word against the oldest one due
        function void check_word(logic [stfl_pkg::OutDataW-1:0] data, logic last,
                                 logic [stfl_pkg::OutUserW-1:0] user);
            tri_word_t w;
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual data %0h last %0b user %0h",
                         $time, data, last, user);
                return;
            end
            w = words_due.pop_front();
            compare("out_s", w.s, data[31:0]);
            compare("out_t", w.t, data[63:32]);
            compare("out_index", w.idx, data[74:64]);
            compare("tri_last", w.last, last);
            compare("list_done", w.done, user[0]);
            compare("error_code", w.err, user[2:1]);
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [stfl_pkg::InDataW-1:0]  s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [stfl_pkg::OutDataW-1:0] m_tdata;
    logic                          m_tlast;
    logic [stfl_pkg::OutUserW-1:0] m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [11:0]                   cfg_data  = '0;

    tri_list_scoreboard sb = new();
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int cur_vc       = stfl_pkg::VertexCountReset;
    int items_sent   = 0;
    int stall_cycles = 0;

    strip_fan_to_triangle_list_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Check output words, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Count cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= StallLimit);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one input word, idling first at random
    task automatic push_word(input logic act, input logic [12:0] cnt, input logic [31:0] s,
                             input logic [31:0] t, input logic [10:0] idx);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, t, s, cnt};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_item(act, cnt, s, t, idx);
        items_sent++;
    endtask

    task automatic send_header(input logic [12:0] cnt);
        push_word(1'b0, cnt, $urandom, $urandom, 11'($urandom_range(0, 2047)));
    endtask

    task automatic send_record(input logic [10:0] idx);
        push_word(1'b1, 13'($urandom), $urandom, $urandom, idx);
    endtask

    function automatic logic [10:0] pick_index(int bad_pct);
        int lim;
        lim = (cur_vc > stfl_pkg::MaxVertices) ? stfl_pkg::MaxVertices : cur_vc;
        if ($urandom_range(0, 99) < bad_pct)
            return 11'($urandom_range(0, 2047));
        return 11'($urandom_range(0, lim - 1));
    endfunction

    // Send a whole primitive, with the odd misplaced header inside it
    task automatic send_primitive(input int mag, input bit fan, input int bad_pct);
        logic [12:0] cnt;
        logic [12:0] stray;
        int i;
        cnt = fan ? 13'(-mag) : 13'(mag);
        send_header(cnt);
        for (i = 0; i < mag; i++) begin
            if ($urandom_range(0, 99) < 4) begin
                stray = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(0, 8191));
                send_header(stray);
            end
            send_record(pick_index(bad_pct));
        end
    endtask

    // Drop valid and wait until every due word has left the block
    task automatic drain_words();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [11:0] v);
        drain_words();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_vertex_count(v);
        cur_vc = v;
    endtask

    task automatic random_phase(input int mag_big, input bit fan_big);
        int start;
        int r;
        logic [12:0] cnt;
        start = items_sent;
        while (items_sent - start < RandomItemsPerPhase) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_primitive($urandom_range(3, 8), $urandom_range(0, 1), 10);
            end else if (r < 80) begin
                send_header(13'd0);
            end else if (r < 90) begin
                cnt = 13'($urandom_range(1, 2));
                if ($urandom_range(0, 1))
                    cnt = 13'd0 - cnt;
                send_header(cnt);
            end else begin
                send_record(11'($urandom_range(0, 2047)));
            end
        end
        if (mag_big > 0)
            send_primitive(mag_big, fan_big, 3);
    endtask

    initial begin
        src_idle_pct = 31;
        dst_idle_pct = 47;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Terminator, stray record and bad counts outside any primitive
        send_header(13'd0);
        push_word(1'b1, 13'h1FFF, 32'hFFFF_FFFF, 32'h0000_0000, 11'd2047);
        send_header(13'd1);
        send_header(13'h1FFE);
        // Strip of four with misplaced header and terminator inside
        send_header(13'd4);
        push_word(1'b1, 13'd0, 32'h0000_0000, 32'h0000_0000, 11'd0);
        push_word(1'b1, 13'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047);
        send_header(13'h1FFD);
        send_header(13'd0);
        send_record(11'd1);
        send_record(11'd2);
        // Fan of four pivoting on its first record
        send_header(13'h1FFC);
        send_record(11'd10);
        send_record(11'd11);
        send_record(11'd12);
        send_record(11'd13);
        send_header(13'd0);

        // Out-of-range indices on early records and on triangles
        write_vertex_count(12'd3);
        send_header(13'd3);
        send_record(11'd5);
        send_record(11'd1);
        send_record(11'd2);
        send_header(13'h1FFD);
        send_record(11'd0);
        send_record(11'd1);
        send_record(11'd3);
        write_vertex_count(12'd2048);

        // Random phases under varied back-pressure and register settings
        write_vertex_count(12'd1);
        random_phase(0, 1'b0);

        src_idle_pct = 47;
        dst_idle_pct = 31;
        write_vertex_count(12'($urandom_range(4, 200)));
        random_phase(LongPrimRecords, 1'b1);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_vertex_count(12'd2047);
        random_phase(LongPrimRecords, 1'b0);

        drain_words();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
